### hdl/ccc_pkg.sv
package ccc_pkg;

    localparam int MAX_LEN_DEF     = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int IN_SAMPLE_BITS  = 16;
    localparam int VALUE_BITS      = 38;
    // normalized magnitude, 0..2^15 inclusive
    localparam int QMAG_BITS       = 16;

    typedef enum logic [1:0] {
        OP_LOAD_FIRST  = 2'd0,
        OP_LOAD_SECOND = 2'd1,
        OP_COMPUTE     = 2'd2,
        OP_NOP         = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode                            opcode;
        logic signed [IN_SAMPLE_BITS-1:0]   sample;
    } t_in_word;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0]       value;
        logic                               last;
    } t_out_word;

endpackage

### hdl/circular_cross_correlation.sv
// Circular cross-correlation of two sample vectors.
// Input channel (i_in_valid / o_in_ready / i_in): load words append one sample
// to the first or second store, one word per cycle while idle; a compute word
// starts a run. The longer vector is the signal (the second on a tie).
// Output channel (o_out_valid / i_out_ready / o_out): one word per signal
// position, last set on the final one; the stores are then emptied.
// A run holds o_in_ready low. Each position reads the stores once per filter
// tap (none with no filter taps), with product and accumulate stages behind
// the reads; in normalize mode two serial multiplies then run side by side and
// the quotient is found one bit per add/compare step. The word is handed over
// through the output register.
// The output word sits in a register until taken; a stalled receiver simply
// holds the run in place, nothing is dropped.
// i_cfg_we writes the normalize bit from i_cfg_wdata; write it only while idle.
// Synchronous reset empties both stores (counts to zero), clears normalize
// and returns the sequencer to idle; there is no clearing pass.
module circular_cross_correlation #(
    parameter int MAX_LEN     = ccc_pkg::MAX_LEN_DEF,
    parameter int SAMPLE_BITS = ccc_pkg::SAMPLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ccc_pkg::t_in_word  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ccc_pkg::t_out_word o_out,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata
);
    import ccc_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int EW = 2 * SB + 6;

    typedef enum logic [2:0] {S_IDLE, S_SETUP, S_TAPS, S_WAIT, S_FINISH, S_NORM, S_OUT}
        t_state;

    t_state r_state;
    logic   r_normalize;
    logic [CW-1:0] r_cnt1, r_cnt2, r_slen, r_flen, r_i, r_j;
    logic [AW-1:0] r_base, r_idx;
    logic   r_sel1;          // first store is the signal
    logic   r_v1, r_v2;
    logic signed [2*SB-1:0] r_pab;
    logic [2*SB-1:0] r_paa, r_pbb;
    logic signed [EW-1:0] r_sum;
    logic [EW-1:0] r_es, r_ef;
    logic   r_out_valid;
    t_out_word r_out;
    logic   r_nstart;

    logic [SB-1:0] s_samp;
    logic s_acc, s_we1, s_we2;
    logic [AW-1:0] s_ra1, s_ra2;
    logic [SB-1:0] s_rd1, s_rd2;
    logic signed [SB-1:0] s_a, s_b;
    logic signed [2*SB-1:0] s_sq_a, s_sq_b;
    logic [EW-1:0] s_mag;
    logic [VALUE_BITS-1:0] s_raw, s_nval;
    logic [CW-1:0] s_slen, s_flen, s_center, s_base;
    logic [CW-1:0] s_idx_inc, s_base_inc;
    logic s_ndone;
    logic [QMAG_BITS-1:0] s_q;
    logic s_out_take;

    // samples wider than the input field read as zero-extended
    always_comb begin
        for (int b = 0; b < SB; b++) begin
            s_samp[b] = (b < IN_SAMPLE_BITS) ? i_in.sample[b] : 1'b0;
        end
    end

    assign s_acc = i_in_valid && o_in_ready;
    assign s_we1 = s_acc && i_in.opcode == OP_LOAD_FIRST && r_cnt1 < CW'(MAX_LEN);
    assign s_we2 = s_acc && i_in.opcode == OP_LOAD_SECOND && r_cnt2 < CW'(MAX_LEN);

    assign s_ra1 = r_sel1 ? r_idx : r_j[AW-1:0];
    assign s_ra2 = r_sel1 ? r_j[AW-1:0] : r_idx;

    ccc_store #(.DEPTH(MAX_LEN), .DW(SB)) u_store1 (
        .i_clk(i_clk), .i_we(s_we1), .i_waddr(r_cnt1[AW-1:0]), .i_wdata(s_samp),
        .i_raddr(s_ra1), .o_rdata(s_rd1)
    );
    ccc_store #(.DEPTH(MAX_LEN), .DW(SB)) u_store2 (
        .i_clk(i_clk), .i_we(s_we2), .i_waddr(r_cnt2[AW-1:0]), .i_wdata(s_samp),
        .i_raddr(s_ra2), .o_rdata(s_rd2)
    );

    assign s_a = r_sel1 ? $signed(s_rd1) : $signed(s_rd2);
    assign s_b = r_sel1 ? $signed(s_rd2) : $signed(s_rd1);

    // full-width squares, never negative
    assign s_sq_a = s_a * s_a;
    assign s_sq_b = s_b * s_b;

    assign s_mag = r_sum[EW-1] ? EW'(-r_sum) : EW'(r_sum);

    ccc_norm #(.EW(EW)) u_norm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_nstart),
        .i_mag(s_mag), .i_es(r_es), .i_ef(r_ef),
        .o_done(s_ndone), .o_q(s_q)
    );

    always_comb begin
        for (int b = 0; b < VALUE_BITS; b++) begin
            s_raw[b] = (b < EW) ? r_sum[b] : r_sum[EW-1];
        end
        s_nval = r_sum[EW-1] ? -VALUE_BITS'(s_q) : VALUE_BITS'(s_q);
    end

    always_comb begin
        if (r_cnt1 > r_cnt2) begin
            s_slen = r_cnt1;
            s_flen = r_cnt2;
        end else begin
            s_slen = r_cnt2;
            s_flen = r_cnt1;
        end
        s_center = s_flen >> 1;
        s_base   = (s_center == '0) ? '0 : s_slen - s_center;
        s_idx_inc  = CW'(r_idx) + 1'b1;
        s_base_inc = CW'(r_base) + 1'b1;
    end

    assign s_out_take = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_normalize <= 1'b0;
            r_cnt1      <= '0;
            r_cnt2      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
            r_nstart    <= 1'b0;
        end else begin
            if (i_cfg_we) r_normalize <= i_cfg_wdata;
            if (s_we1) r_cnt1 <= r_cnt1 + 1'b1;
            if (s_we2) r_cnt2 <= r_cnt2 + 1'b1;

            r_v1     <= (r_state == S_TAPS);
            r_v2     <= r_v1;
            r_nstart <= (r_state == S_FINISH) && r_normalize && r_es != '0 && r_ef != '0;
            if (r_v1) begin
                r_pab <= s_a * s_b;
                r_paa <= $unsigned(s_sq_a);
                r_pbb <= $unsigned(s_sq_b);
            end
            if (r_v2) begin
                r_sum <= r_sum + EW'(r_pab);
                r_es  <= r_es + EW'(r_paa);
                r_ef  <= r_ef + EW'(r_pbb);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_acc && i_in.opcode == OP_COMPUTE && s_slen != '0) begin
                        r_sel1  <= r_cnt1 > r_cnt2;
                        r_slen  <= s_slen;
                        r_flen  <= s_flen;
                        r_base  <= s_base[AW-1:0];
                        r_i     <= '0;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_sum   <= '0;
                    r_es    <= '0;
                    r_ef    <= '0;
                    r_idx   <= r_base;
                    r_j     <= '0;
                    r_state <= (r_flen == '0) ? S_FINISH : S_TAPS;
                end
                S_TAPS: begin
                    r_idx <= (s_idx_inc == r_slen) ? '0 : s_idx_inc[AW-1:0];
                    r_j   <= r_j + 1'b1;
                    if (r_j + 1'b1 == r_flen) r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (!r_v1 && !r_v2) r_state <= S_FINISH;
                end
                S_FINISH: begin
                    r_out.last <= (r_i + 1'b1 == r_slen);
                    if (r_normalize && r_es != '0 && r_ef != '0) begin
                        r_state  <= S_NORM;
                    end else begin
                        r_out.value <= r_normalize ? '0 : s_raw;
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_NORM: begin
                    if (s_ndone) begin
                        r_out.value <= s_nval;
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (s_out_take) begin
                        r_out_valid <= 1'b0;
                        if (r_i + 1'b1 == r_slen) begin
                            r_cnt1  <= '0;
                            r_cnt2  <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_base  <= (s_base_inc == r_slen) ? '0 : s_base_inc[AW-1:0];
                            r_state <= S_SETUP;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule

### hdl/ccc_store.sv
module ccc_store #(
    parameter int DEPTH = 64,
    parameter int DW    = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/ccc_norm.sv
// Largest m in 0..2^15 with (2m-1)^2 * es * ef <= s^2 * 2^32, one bit of m per
// step. m^2*P and m*P are kept incrementally so each step is shifts and adds.
module ccc_norm #(
    parameter int EW = 38
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [EW-1:0]                   i_mag,
    input  logic [EW-1:0]                   i_es,
    input  logic [EW-1:0]                   i_ef,
    output logic                            o_done,
    output logic [ccc_pkg::QMAG_BITS-1:0]   o_q
);
    import ccc_pkg::*;

    localparam int PW = 2 * EW;
    localparam int W  = PW + 34;
    localparam int CNTW = $clog2(EW);
    localparam int KW = $clog2(QMAG_BITS);

    typedef enum logic [2:0] {N_IDLE, N_MUL, N_INIT, N_ADD, N_CMP, N_DONE} t_nstate;

    t_nstate r_state;
    logic [CNTW-1:0] r_cnt;
    logic [PW-1:0] r_ma, r_p, r_sa, r_r;
    logic [EW-1:0] r_mb, r_sb;
    logic [W-1:0]  r_a, r_b, r_c, r_pb, r_pbb, r_ta, r_tb;
    logic [QMAG_BITS-1:0] r_m;
    logic [KW-1:0] r_k;
    logic          r_done;

    logic [W-1:0] s_t, s_rhs, s_bit;
    logic         s_pass;

    always_comb begin
        s_t    = (r_ta << 2) + W'(r_p) - (r_tb << 2);
        s_rhs  = W'(r_r) << 32;
        s_pass = (s_t <= s_rhs) && !r_m[QMAG_BITS-1];
        s_bit  = W'(1) << r_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == N_DONE);
            unique case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        r_ma    <= PW'(i_es);
                        r_mb    <= i_ef;
                        r_sa    <= PW'(i_mag);
                        r_sb    <= i_mag;
                        r_p     <= '0;
                        r_r     <= '0;
                        r_cnt   <= '0;
                        r_state <= N_MUL;
                    end
                end
                N_MUL: begin
                    if (r_mb[0]) r_p <= r_p + r_ma;
                    if (r_sb[0]) r_r <= r_r + r_sa;
                    r_ma  <= r_ma << 1;
                    r_sa  <= r_sa << 1;
                    r_mb  <= r_mb >> 1;
                    r_sb  <= r_sb >> 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNTW'(EW - 1)) r_state <= N_INIT;
                end
                N_INIT: begin
                    r_a     <= '0;
                    r_b     <= '0;
                    r_c     <= '0;
                    r_pb    <= W'(r_p) << (QMAG_BITS - 1);
                    r_pbb   <= W'(r_p) << (2 * (QMAG_BITS - 1));
                    r_m     <= '0;
                    r_k     <= KW'(QMAG_BITS - 1);
                    r_state <= N_ADD;
                end
                N_ADD: begin
                    r_ta    <= r_a + r_c + r_pbb;
                    r_tb    <= r_b + r_pb;
                    r_state <= N_CMP;
                end
                N_CMP: begin
                    if (s_pass) begin
                        r_a <= r_ta;
                        r_b <= r_tb;
                        r_c <= (r_c + (r_pbb << 1)) >> 1;
                        r_m <= r_m | s_bit[QMAG_BITS-1:0];
                    end else begin
                        r_c <= r_c >> 1;
                    end
                    r_pb  <= r_pb >> 1;
                    r_pbb <= r_pbb >> 2;
                    if (r_k == '0) begin
                        r_state <= N_DONE;
                    end else begin
                        r_k     <= r_k - 1'b1;
                        r_state <= N_ADD;
                    end
                end
                N_DONE: begin
                    r_state <= N_IDLE;
                end
                default: r_state <= N_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_q    = r_m;
endmodule

### tb/circular_cross_correlation_tb.sv
module circular_cross_correlation_tb;
    import ccc_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam int DRAIN_CYCLES = 200;
    localparam int IN_BITS = $bits(t_in_word);

    typedef struct {
        bit                  is_cfg;
        t_opcode             op;
        logic signed [15:0]  smp;
        bit                  known;
        longint              known_val;
    } t_stim_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in_word   i_in = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_word  o_out;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_wdata = 1'b0;

    circular_cross_correlation dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    int        first_smp [STORE_DEPTH];
    int        second_smp [STORE_DEPTH];
    int        first_len;
    int        second_len;
    bit        norm_mode;
    t_out_word corr_q [$];

    int        err_count;
    bit        calm;
    int        stall_left;
    t_stim_row rows [$];

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // round(s * 2^15 / sqrt(es * ef)) by search on the squared comparison
    function automatic longint unsigned norm_q15(longint unsigned s, longint unsigned es,
                                                 longint unsigned ef);
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [127:0] wide_s;
        longint unsigned lo, hi, m, odd;
        wide_s = s;
        rhs = (wide_s * wide_s) << 32;
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
            m = lo + (hi - lo + 1) / 2;
            odd = 2 * m - 1;
            lhs = 128'(odd * odd) * 128'(es) * 128'(ef);
            if (lhs <= rhs) lo = m;
            else hi = m - 1;
        end
        return lo;
    endfunction

    // returns 1 for a load that fits its store and for every compute word
    function automatic bit predict(input t_in_word w);
        int sig [STORE_DEPTH];
        int fil [STORE_DEPTH];
        int slen, flen, ctr, idx;
        longint sum, a, b;
        longint unsigned es, ef, q;
        t_out_word r;
        case (w.opcode)
            OP_LOAD_FIRST: begin
                if (first_len >= STORE_DEPTH) return 0;
                first_smp[first_len++] = int'(w.sample);
                return 1;
            end
            OP_LOAD_SECOND: begin
                if (second_len >= STORE_DEPTH) return 0;
                second_smp[second_len++] = int'(w.sample);
                return 1;
            end
            OP_COMPUTE: begin
                if (first_len > second_len) begin
                    sig = first_smp; slen = first_len; fil = second_smp; flen = second_len;
                end else begin
                    sig = second_smp; slen = second_len; fil = first_smp; flen = first_len;
                end
                ctr = flen / 2;
                for (int i = 0; i < slen; i++) begin
                    sum = 0; es = 0; ef = 0;
                    for (int j = 0; j < flen; j++) begin
                        idx = (i + slen - ctr + j) % slen;
                        a = sig[idx];
                        b = fil[j];
                        sum += a * b;
                        es += longint'(a * a);
                        ef += longint'(b * b);
                    end
                    if (norm_mode) begin
                        if (es == 0 || ef == 0) begin
                            r.value = '0;
                        end else begin
                            q = norm_q15(sum < 0 ? -sum : sum, es, ef);
                            r.value = sum < 0 ? 38'(-longint'(q)) : 38'(q);
                        end
                    end else begin
                        r.value = 38'(sum);
                    end
                    r.last = (i + 1 == slen);
                    corr_q.push_back(r);
                end
                first_len = 0;
                second_len = 0;
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    task automatic send(input t_in_word w, output bit counted);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        counted = predict(w);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (corr_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_norm(input bit v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        norm_mode = v;
    endtask

    function automatic logic signed [15:0] rand_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'sh7fff;
        if (r == 1) return 16'sh8000;
        if (r == 2) return 16'sh0000;
        if (r < 5) return 16'($signed($urandom_range(0, 64)) - 32);
        return 16'($urandom());
    endfunction

    function automatic int rand_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 8);
        if (r < 88) return $urandom_range(9, 63);
        if (r < 95) return STORE_DEPTH;
        return STORE_DEPTH + 2;
    endfunction

    function automatic void add_row(bit c, t_opcode op, int smp, bit known = 0,
                                    longint kv = 0);
        t_stim_row row;
        row.is_cfg = c;
        row.op = op;
        row.smp = 16'(smp);
        row.known = known;
        row.known_val = kv;
        rows.push_back(row);
    endfunction

    // output side: check accepted words, randomize ready
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (corr_q.size() == 0) begin
                    report($sformatf("unexpected word value=%0d last=%0b",
                                     o_out.value, o_out.last));
                end else begin
                    if (o_out.value !== corr_q[0].value)
                        report($sformatf("value %0d, want %0d",
                                         o_out.value, corr_q[0].value));
                    if (o_out.last !== corr_q[0].last)
                        report($sformatf("last %0b, want %0b", o_out.last, corr_q[0].last));
                    void'(corr_q.pop_front());
                end
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        t_in_word w;
        bit counted;
        int q_mark, n1, n2, items, r;
        err_count = 0;
        first_len = 0;
        second_len = 0;
        norm_mode = 0;
        calm = 0;
        stall_left = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(1, OP_NOP, 0);
        add_row(0, OP_LOAD_FIRST, 32767);
        add_row(0, OP_LOAD_SECOND, -32768);
        add_row(0, OP_COMPUTE, 0, 1, -64'sd1073709056);
        add_row(0, OP_LOAD_FIRST, -32768);
        add_row(0, OP_LOAD_FIRST, -32768);
        add_row(0, OP_LOAD_SECOND, -32768);
        add_row(0, OP_COMPUTE, 0, 1, 64'sd1073741824);
        add_row(0, OP_NOP, 16'hffff);
        add_row(0, OP_COMPUTE, 0);               // both stores empty
        add_row(0, OP_LOAD_SECOND, 123);
        add_row(0, OP_COMPUTE, 0, 1, 0);         // empty filter
        add_row(0, OP_LOAD_FIRST, 0);
        add_row(0, OP_LOAD_SECOND, 0);
        add_row(0, OP_COMPUTE, 0, 1, 0);
        add_row(1, OP_NOP, 1);
        add_row(0, OP_LOAD_FIRST, 1000);
        add_row(0, OP_LOAD_SECOND, 1000);
        add_row(0, OP_COMPUTE, 0, 1, 32768);
        add_row(0, OP_LOAD_FIRST, -5);
        add_row(0, OP_LOAD_SECOND, 7);
        add_row(0, OP_COMPUTE, 0, 1, -32768);
        add_row(0, OP_LOAD_FIRST, 0);
        add_row(0, OP_LOAD_SECOND, 5);
        add_row(0, OP_COMPUTE, 0, 1, 0);         // zero denominator
        add_row(0, OP_LOAD_SECOND, 9);
        add_row(0, OP_LOAD_SECOND, -9);
        add_row(0, OP_COMPUTE, 0, 1, 0);         // empty filter, normalized

        foreach (rows[k]) begin
            if (rows[k].is_cfg) begin
                write_norm(rows[k].smp[0]);
            end else begin
                w.opcode = rows[k].op;
                w.sample = rows[k].smp;
                q_mark = corr_q.size();
                send(w, counted);
                if (rows[k].known)
                    for (int e = q_mark; e < corr_q.size(); e++)
                        if (corr_q[e].value !== 38'(rows[k].known_val))
                            report($sformatf("row %0d predicts %0d, table has %0d",
                                             k, corr_q[e].value, rows[k].known_val));
            end
        end

        write_norm(0);
        items = 0;
        while (items < 360) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                calm = $urandom_range(0, 2) == 0;
                write_norm($urandom_range(0, 1));
            end else if (r < 85) begin
                n1 = rand_len();
                n2 = rand_len();
                for (int k = 0; k < n1 + n2; k++) begin
                    // interleave the two stores at random
                    if ((k < n1 && $urandom_range(0, 1)) || k - n1 >= 0) begin
                        w.opcode = (k < n1) ? OP_LOAD_FIRST : OP_LOAD_SECOND;
                    end else begin
                        w.opcode = OP_LOAD_SECOND;
                    end
                    w.sample = rand_sample();
                    send(w, counted);
                    items += counted;
                end
                w.opcode = OP_COMPUTE;
                w.sample = 16'($urandom());
                send(w, counted);
                items += counted;
            end else begin
                w = t_in_word'(IN_BITS'($urandom()));
                send(w, counted);
                items += counted;
            end
        end
        calm = 0;
        write_norm(1);
        drain();

        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
